// ===== hw/rtl/usx_pkg.sv =====
// ----------------------------------------------------------------------------
// usx_pkg
// shared types, constants and helpers of the serial transceiver
// ----------------------------------------------------------------------------
`default_nettype none

package usx_pkg;

  localparam int unsigned TIMER_W      = 16;
  localparam int unsigned DATA_W       = 8;
  localparam int unsigned FRAME_W      = DATA_W + 3;
  localparam int unsigned BITCNT_W     = 4;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned MIN_PERIOD   = 4;
  localparam int unsigned MIN_DATA     = 5;
  localparam int unsigned MAX_DATA     = 8;

  localparam logic [TIMER_W-1:0]  RST_PERIOD = TIMER_W'(1667);
  localparam logic [3:0]          RST_DBITS  = 4'd8;
  localparam logic [1:0]          RST_SBITS  = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIT_PERIOD = 2'd0,
    REG_DATA_BITS  = 2'd1,
    REG_STOP_BITS  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [TIMER_W-1:0] bit_period;
    logic [3:0]         data_bits;
    logic [1:0]         stop_bits;
  } cfg_t;

  typedef struct packed {
    logic              rx_line;
    logic              tx_start;
    logic [DATA_W-1:0] tx_byte;
  } item_t;

  typedef enum logic [3:0] {
    RX_IDLE  = 4'b0001,
    RX_START = 4'b0010,
    RX_DATA  = 4'b0100,
    RX_WAIT  = 4'b1000
  } rx_phase_t;

  function automatic logic [TIMER_W-1:0] eff_period(input logic [TIMER_W-1:0] p);
    eff_period = (p < TIMER_W'(MIN_PERIOD)) ? TIMER_W'(MIN_PERIOD) : p;
  endfunction

  function automatic logic [BITCNT_W-1:0] eff_dbits(input logic [3:0] d);
    logic [BITCNT_W-1:0] r;
    r = d;
    if (d < 4'(MIN_DATA)) r = BITCNT_W'(MIN_DATA);
    if (d > 4'(MAX_DATA)) r = BITCNT_W'(MAX_DATA);
    eff_dbits = r;
  endfunction

  function automatic logic [1:0] eff_sbits(input logic [1:0] s);
    logic [1:0] r;
    r = s;
    if (s == 2'd0) r = 2'd1;
    if (s == 2'd3) r = 2'd2;
    eff_sbits = r;
  endfunction

  function automatic logic [DATA_W-1:0] char_mask(input logic [BITCNT_W-1:0] db);
    char_mask = {DATA_W{1'b1}} >> (BITCNT_W'(DATA_W) - db);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/uart_serial_transceiver.sv =====
// ----------------------------------------------------------------------------
// uart_serial_transceiver
// async serial transmitter and receiver stepped, when nothing stalls, by one tick beat per cycle
// ----------------------------------------------------------------------------
//  port group  direction  beat content
//  in_*        input      rx_line, tx_start, tx_byte (one clock tick)
//  out_*       output     tx_line, tx_ready, rx_valid, rx_byte (one per tick)
//  cfg_*       input      register index and write data
//
//  one tick beat in and one result beat out per cycle when nothing stalls
//  each beat passes the queue entry, then the state update into the out register
//  the two-entry queue takes beats while the out register is stalled
//  rst_n synchronous, active low; config registers reset to 1667 / 8 / 2
// ----------------------------------------------------------------------------
`default_nettype none

module uart_serial_transceiver (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_rx_line,
  input  wire logic                              in_tx_start,
  input  wire logic [usx_pkg::DATA_W-1:0]        in_tx_byte,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_tx_line,
  output logic                                   out_tx_ready,
  output logic                                   out_rx_valid,
  output logic [usx_pkg::DATA_W-1:0]             out_rx_byte,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [usx_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [usx_pkg::CFG_DATA_W-1:0]    cfg_data
);

  usx_pkg::cfg_t  cfg_r, cfg_nxt;
  usx_pkg::item_t in_item;
  usx_pkg::item_t q_item;
  logic           q_valid;
  logic           q_pop;

  assign cfg_ready = 1'b1;
  assign in_item   = '{rx_line: in_rx_line, tx_start: in_tx_start, tx_byte: in_tx_byte};

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        usx_pkg::REG_BIT_PERIOD: cfg_nxt.bit_period = cfg_data[usx_pkg::TIMER_W-1:0];
        usx_pkg::REG_DATA_BITS:  cfg_nxt.data_bits  = cfg_data[3:0];
        usx_pkg::REG_STOP_BITS:  cfg_nxt.stop_bits  = cfg_data[1:0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit_period <= usx_pkg::RST_PERIOD;
      cfg_r.data_bits  <= usx_pkg::RST_DBITS;
      cfg_r.stop_bits  <= usx_pkg::RST_SBITS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  usx_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  usx_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_tx_line  (out_tx_line),
    .out_tx_ready (out_tx_ready),
    .out_rx_valid (out_rx_valid),
    .out_rx_byte  (out_rx_byte)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/usx_front.sv =====
// ----------------------------------------------------------------------------
// usx_front
// input side: takes tick beats and holds them in a two-entry queue
// ----------------------------------------------------------------------------
`default_nettype none

module usx_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire usx_pkg::item_t in_item,
  output logic               q_valid,
  output usx_pkg::item_t     q_item,
  input  wire logic          q_pop
);

  usx_pkg::item_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       pop;

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/usx_core.sv =====
// ----------------------------------------------------------------------------
// usx_core
// back end: transmitter and receiver state, one tick per queue entry
// ----------------------------------------------------------------------------
`default_nettype none

module usx_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire usx_pkg::cfg_t                cfg,
  input  wire logic                         q_valid,
  input  wire usx_pkg::item_t               q_item,
  output logic                              q_pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_tx_line,
  output logic                              out_tx_ready,
  output logic                              out_rx_valid,
  output logic [usx_pkg::DATA_W-1:0]        out_rx_byte
);

  localparam int unsigned TW = usx_pkg::TIMER_W;
  localparam int unsigned DW = usx_pkg::DATA_W;
  localparam int unsigned FW = usx_pkg::FRAME_W;
  localparam int unsigned BW = usx_pkg::BITCNT_W;

  logic [FW-1:0] tx_shift_r, tx_shift_nxt;
  logic [BW-1:0] tx_left_r, tx_left_nxt;
  logic [TW-1:0] tx_timer_r, tx_timer_nxt;
  usx_pkg::rx_phase_t rx_phase_r, rx_phase_nxt;
  logic [DW-1:0] rx_shift_r, rx_shift_nxt;
  logic [BW-1:0] rx_idx_r, rx_idx_nxt;
  logic [TW-1:0] rx_timer_r, rx_timer_nxt;

  logic          out_valid_r;
  logic          tx_line_r, tx_line_nxt;
  logic          tx_ready_r, tx_ready_nxt;
  logic          rx_valid_r, rx_valid_nxt;
  logic [DW-1:0] rx_byte_r, rx_byte_nxt;

  logic [TW-1:0] period;
  logic [BW-1:0] dbits;
  logic [DW-1:0] mask;
  logic [FW-1:0] shift_mid;
  logic [BW-1:0] left_mid;
  logic [TW-1:0] timer_mid;
  logic [TW-1:0] tx_dec;
  logic [TW-1:0] rx_dec;

  assign q_pop        = q_valid && (!out_valid_r || !out_stall);
  assign out_valid    = out_valid_r;
  assign out_tx_line  = tx_line_r;
  assign out_tx_ready = tx_ready_r;
  assign out_rx_valid = rx_valid_r;
  assign out_rx_byte  = rx_byte_r;

  assign period = usx_pkg::eff_period(cfg.bit_period);
  assign dbits  = usx_pkg::eff_dbits(cfg.data_bits);
  assign mask   = usx_pkg::char_mask(dbits);

  // transmitter
  always_comb begin
    tx_ready_nxt = (tx_left_r == '0);
    shift_mid    = tx_shift_r;
    left_mid     = tx_left_r;
    timer_mid    = tx_timer_r;
    if (tx_ready_nxt && q_item.tx_start) begin
      shift_mid = {2'b11, q_item.tx_byte | ~mask, 1'b0};
      left_mid  = BW'(1) + dbits + BW'(usx_pkg::eff_sbits(cfg.stop_bits));
      timer_mid = period;
    end
    tx_line_nxt  = 1'b1;
    tx_shift_nxt = shift_mid;
    tx_left_nxt  = left_mid;
    tx_timer_nxt = timer_mid;
    tx_dec       = timer_mid - TW'(1);
    if (left_mid != '0) begin
      tx_line_nxt  = shift_mid[0];
      tx_timer_nxt = tx_dec;
      if (tx_dec == '0) begin
        tx_shift_nxt = {1'b1, shift_mid[FW-1:1]};
        tx_left_nxt  = left_mid - BW'(1);
        tx_timer_nxt = period;
      end
    end
  end

  // receiver
  always_comb begin
    rx_phase_nxt = rx_phase_r;
    rx_shift_nxt = rx_shift_r;
    rx_idx_nxt   = rx_idx_r;
    rx_timer_nxt = rx_timer_r;
    rx_valid_nxt = 1'b0;
    rx_byte_nxt  = '0;
    rx_dec       = rx_timer_r - TW'(1);
    unique case (rx_phase_r)
      usx_pkg::RX_START: begin
        rx_timer_nxt = rx_dec;
        if (rx_dec == '0) begin
          rx_phase_nxt = usx_pkg::RX_DATA;
          rx_timer_nxt = period;
        end
      end
      usx_pkg::RX_DATA: begin
        rx_timer_nxt = rx_dec;
        if (rx_dec == '0) begin
          rx_shift_nxt = rx_shift_r | (DW'(q_item.rx_line) << rx_idx_r[2:0]);
          rx_idx_nxt   = rx_idx_r + BW'(1);
          rx_timer_nxt = period;
          if (rx_idx_nxt >= dbits) begin
            rx_valid_nxt = 1'b1;
            rx_byte_nxt  = rx_shift_nxt & mask;
            rx_phase_nxt = usx_pkg::RX_WAIT;
          end
        end
      end
      usx_pkg::RX_WAIT: begin
        if (q_item.rx_line) begin
          rx_phase_nxt = usx_pkg::RX_IDLE;
        end
      end
      default: begin
        rx_phase_nxt = usx_pkg::RX_IDLE;
        if (!q_item.rx_line) begin
          rx_phase_nxt = usx_pkg::RX_START;
          rx_shift_nxt = '0;
          rx_idx_nxt   = '0;
          rx_timer_nxt = period >> 1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_shift_r  <= '1;
      tx_left_r   <= '0;
      tx_timer_r  <= '0;
      rx_phase_r  <= usx_pkg::RX_IDLE;
      rx_shift_r  <= '0;
      rx_idx_r    <= '0;
      rx_timer_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        tx_shift_r  <= tx_shift_nxt;
        tx_left_r   <= tx_left_nxt;
        tx_timer_r  <= tx_timer_nxt;
        rx_phase_r  <= rx_phase_nxt;
        rx_shift_r  <= rx_shift_nxt;
        rx_idx_r    <= rx_idx_nxt;
        rx_timer_r  <= rx_timer_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      tx_line_r  <= tx_line_nxt;
      tx_ready_r <= tx_ready_nxt;
      rx_valid_r <= rx_valid_nxt;
      rx_byte_r  <= rx_byte_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb_uart_serial_transceiver.sv =====
// ----------------------------------------------------------------------------
// tb_uart_serial_transceiver
// self-checking testbench for the tick-stepped serial transceiver
// ----------------------------------------------------------------------------
// Each input beat is one clock tick of line timing: the receive line level,
// a send request and the character to send. The bench builds ticks that
// mostly carry well-formed serial frames on the receive line, with idle
// stretches, short glitches and broken frames mixed in, and random send
// requests. It also carries a cycle-level model of the transmitter and
// receiver that predicts every result beat; beats are compared field by field
// in order. Register settings change between groups of ticks while frames may
// still be in flight. Clamped, minimum and maximum settings are all used.
// Both handshake sides idle in random bursts, except in the closing stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_uart_serial_transceiver;
  timeunit 1ns;
  timeprecision 1ps;

  import usx_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned N_PHASES = 9;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [4:0] PROBE_CHAR = 5'b01101;

  localparam int unsigned PHASE_PERIOD [N_PHASES] = '{4, 0, 6, 3, 9, 5, 13, 4, 4};
  localparam int unsigned PHASE_DBITS  [N_PHASES] = '{8, 15, 0, 6, 7, 4, 9, 5, 8};
  localparam int unsigned PHASE_SBITS  [N_PHASES] = '{2, 3, 0, 1, 2, 1, 3, 2, 1};

  typedef struct packed {
    logic              tx_line;
    logic              tx_ready;
    logic              rx_valid;
    logic [DATA_W-1:0] rx_byte;
  } levels_t;

  typedef struct {
    logic        lvl;
    int unsigned len;
  } line_run_t;

  typedef struct {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
  } reg_write_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_rx_line = 1'b1;
  logic                  in_tx_start = 1'b0;
  logic [DATA_W-1:0]     in_tx_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_tx_line;
  logic                  out_tx_ready;
  logic                  out_rx_valid;
  logic [DATA_W-1:0]     out_rx_byte;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // model state
  cfg_t                link_cfg;
  logic [FRAME_W-1:0]  tx_sr;
  logic [BITCNT_W-1:0] tx_left;
  logic [TIMER_W-1:0]  tx_tmr;
  rx_phase_t           rx_ph;
  logic [DATA_W-1:0]   rx_sr;
  logic [BITCNT_W-1:0] rx_idx;
  logic [TIMER_W-1:0]  rx_tmr;

  item_t       ticks_todo [$];
  levels_t     levels_due [$];
  line_run_t   line_plan [$];
  reg_write_t  reg_plan [$];

  bit          steady = 1'b0;
  int unsigned in_gap = 0;
  int unsigned in_calm = 0;
  int unsigned out_hold = 0;
  int unsigned out_calm = 0;
  int unsigned n_cycles = 0;
  int unsigned n_checked = 0;
  int unsigned n_fail = 0;
  int unsigned n_sent = 0;
  int unsigned n_rcvd = 0;
  int unsigned n_settings = 0;

  uart_serial_transceiver DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_rx_line   (in_rx_line),
    .in_tx_start  (in_tx_start),
    .in_tx_byte   (in_tx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_tx_line  (out_tx_line),
    .out_tx_ready (out_tx_ready),
    .out_rx_valid (out_rx_valid),
    .out_rx_byte  (out_rx_byte),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned ticks_per_bit();
    return (link_cfg.bit_period < MIN_PERIOD) ? MIN_PERIOD : int'(link_cfg.bit_period);
  endfunction

  function automatic int unsigned frame_bits();
    if (link_cfg.data_bits < MIN_DATA) return MIN_DATA;
    if (link_cfg.data_bits > MAX_DATA) return MAX_DATA;
    return link_cfg.data_bits;
  endfunction

  function automatic levels_t step_transceiver(item_t t);
    levels_t             r;
    logic [TIMER_W-1:0]  per;
    logic [BITCNT_W-1:0] db;
    logic [BITCNT_W-1:0] sb;
    logic [DATA_W-1:0]   msk;
    per = TIMER_W'(ticks_per_bit());
    db = BITCNT_W'(frame_bits());
    msk = DATA_W'((1 << db) - 1);
    sb = (link_cfg.stop_bits == 2'd0) ? 4'd1 :
         (link_cfg.stop_bits == 2'd3) ? 4'd2 : BITCNT_W'(link_cfg.stop_bits);
    r = '0;
    r.tx_line = 1'b1;
    r.tx_ready = (tx_left == '0);

    if (r.tx_ready && t.tx_start) begin
      tx_sr = {2'b11, (t.tx_byte & msk) | ~msk, 1'b0};
      tx_left = BITCNT_W'(1 + db + sb);
      tx_tmr = per;
      n_sent++;
    end
    if (tx_left != '0) begin
      r.tx_line = tx_sr[0];
      tx_tmr = tx_tmr - 1'b1;
      if (tx_tmr == '0) begin
        tx_sr = {1'b1, tx_sr[FRAME_W-1:1]};
        tx_left = tx_left - 1'b1;
        tx_tmr = per;
      end
    end

    case (rx_ph)
      RX_START: begin
        rx_tmr = rx_tmr - 1'b1;
        if (rx_tmr == '0) begin
          rx_ph = RX_DATA;
          rx_tmr = per;
        end
      end
      RX_DATA: begin
        rx_tmr = rx_tmr - 1'b1;
        if (rx_tmr == '0) begin
          rx_sr[rx_idx[2:0]] = rx_sr[rx_idx[2:0]] | t.rx_line;
          rx_idx = rx_idx + 1'b1;
          rx_tmr = per;
          if (rx_idx >= db) begin
            r.rx_valid = 1'b1;
            r.rx_byte = rx_sr & msk;
            rx_ph = RX_WAIT;
            n_rcvd++;
          end
        end
      end
      RX_WAIT: begin
        if (t.rx_line) rx_ph = RX_IDLE;
      end
      default: begin
        rx_ph = RX_IDLE;
        if (!t.rx_line) begin
          rx_ph = RX_START;
          rx_sr = '0;
          rx_idx = '0;
          rx_tmr = per >> 1;
        end
      end
    endcase
    return r;
  endfunction

  function automatic void add_run(logic lvl, int unsigned len);
    line_run_t s;
    s.lvl = lvl;
    s.len = len;
    line_plan.push_back(s);
  endfunction

  // next stretch of receive line: mostly clean frames, some idle, glitches, junk
  function automatic void plan_line();
    int unsigned per;
    int unsigned nb;
    int unsigned r;
    per = ticks_per_bit();
    nb = frame_bits();
    r = $urandom_range(0, 99);
    if (r < 70) begin
      if ($urandom_range(0, 1) == 1) add_run(1'b1, $urandom_range(1, per));
      add_run(1'b0, per);
      for (int k = 0; k < nb; k++) add_run(1'($urandom_range(0, 1)), per);
      add_run(1'b1, per * $urandom_range(1, 2));
    end else if (r < 82) begin
      add_run(1'b1, $urandom_range(1, 3 * per));
    end else if (r < 92) begin
      add_run(1'b0, $urandom_range(1, per - 1));
      add_run(1'b1, $urandom_range(1, per));
    end else begin
      repeat ($urandom_range(2, 6)) add_run(1'($urandom_range(0, 1)), $urandom_range(1, 2 * per));
    end
  endfunction

  function automatic logic next_rx_level();
    logic lvl;
    if (line_plan.size() == 0) plan_line();
    lvl = line_plan[0].lvl;
    line_plan[0].len = line_plan[0].len - 1;
    if (line_plan[0].len == 0) void'(line_plan.pop_front());
    return lvl;
  endfunction

  function automatic void queue_ticks(int unsigned n);
    item_t it;
    repeat (n) begin
      it.rx_line = next_rx_level();
      it.tx_start = ($urandom_range(0, 4) == 0);
      it.tx_byte = 8'($urandom());
      ticks_todo.push_back(it);
    end
  endfunction

  function automatic void plan_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    reg_write_t w;
    w.idx = idx;
    w.val = val;
    reg_plan.push_back(w);
  endfunction

  task automatic apply_regs();
    reg_write_t w;
    while (reg_plan.size() != 0) begin
      w = reg_plan.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= w.idx;
      cfg_data <= w.val;
      do @(posedge clk); while (!cfg_ready);
      case (w.idx)
        REG_BIT_PERIOD: link_cfg.bit_period = w.val;
        REG_DATA_BITS:  link_cfg.data_bits = w.val[3:0];
        REG_STOP_BITS:  link_cfg.stop_bits = w.val[1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic settle();
    do @(posedge clk);
    while (ticks_todo.size() != 0 || in_valid || levels_due.size() != 0);
  endtask

  function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_fail++;
    end
  endfunction

  // tick beats into the block
  always @(posedge clk) begin : feed
    item_t cur;
    item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        cur = {in_rx_line, in_tx_start, in_tx_byte};
        levels_due.push_back(step_transceiver(cur));
      end
      if (!in_valid || !in_stall) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (ticks_todo.size() != 0) begin
          nxt = ticks_todo.pop_front();
          in_valid <= 1'b1;
          in_rx_line <= nxt.rx_line;
          in_tx_start <= nxt.tx_start;
          in_tx_byte <= nxt.tx_byte;
          if (!steady) begin
            if (in_calm != 0) in_calm--;
            else if ($urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 16);
            else if ($urandom_range(0, 9) == 0) in_calm = $urandom_range(20, 80);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result beats out of the block
  always @(posedge clk) begin : sink
    levels_t want;
    logic    stall_nxt;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_checked++;
        if (levels_due.size() == 0) begin
          $error("result beat with nothing pending");
          n_fail++;
        end else begin
          want = levels_due.pop_front();
          check_field("tx_line", DATA_W'(want.tx_line), DATA_W'(out_tx_line));
          check_field("tx_ready", DATA_W'(want.tx_ready), DATA_W'(out_tx_ready));
          check_field("rx_valid", DATA_W'(want.rx_valid), DATA_W'(out_rx_valid));
          check_field("rx_byte", want.rx_byte, out_rx_byte);
        end
      end
      stall_nxt = 1'b0;
      if (out_hold != 0) begin
        out_hold--;
        stall_nxt = 1'b1;
      end else if (!steady) begin
        if (out_calm != 0) begin
          out_calm--;
        end else if ($urandom_range(0, 5) == 0) begin
          out_hold = $urandom_range(0, 15);
          stall_nxt = 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
          out_calm = $urandom_range(20, 80);
        end
      end
      out_stall <= stall_nxt;
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("uart_serial_transceiver regression: fail");
      $finish;
    end
  end

  initial begin
    item_t it;
    link_cfg.bit_period = RST_PERIOD;
    link_cfg.data_bits = RST_DBITS;
    link_cfg.stop_bits = RST_SBITS;
    tx_sr = '1;
    tx_left = '0;
    tx_tmr = '0;
    rx_ph = RX_IDLE;
    rx_sr = '0;
    rx_idx = '0;
    rx_tmr = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // quiet line at reset settings
    repeat (3) begin
      it.rx_line = 1'b1;
      it.tx_start = 1'b0;
      it.tx_byte = 8'($urandom());
      ticks_todo.push_back(it);
    end
    settle();

    // clamped settings: shortest bit, fewest data bits, one stop bit
    plan_reg(REG_BIT_PERIOD, 16'd3);
    plan_reg(REG_DATA_BITS, {12'hfff, 4'd4});
    plan_reg(REG_STOP_BITS, 16'hfffc);
    plan_reg(REG_SPARE, 16'hffff);
    apply_regs();
    for (int i = 0; i < 25; i++) begin
      it.tx_start = (i < 2) || (i == 20);
      it.tx_byte = (i == 0) ? 8'hff : (i == 1) ? 8'h00 : 8'($urandom());
      if (i == 0) it.rx_line = 1'b1;
      else if (i < 5) it.rx_line = 1'b0;
      else it.rx_line = PROBE_CHAR[(i - 5) / 4];
      ticks_todo.push_back(it);
    end
    settle();

    for (int p = 0; p < N_PHASES; p++) begin
      if (p == N_PHASES - 1) steady = 1'b1;
      plan_reg(REG_BIT_PERIOD, 16'(PHASE_PERIOD[p]));
      plan_reg(REG_DATA_BITS, {12'($urandom()), 4'(PHASE_DBITS[p])});
      plan_reg(REG_STOP_BITS, {14'($urandom()), 2'(PHASE_SBITS[p])});
      if (p % 3 == 1) plan_reg(REG_SPARE, 16'($urandom()));
      apply_regs();
      queue_ticks($urandom_range(60, 100));
      settle();
    end

    // longest bit period
    plan_reg(REG_BIT_PERIOD, 16'hffff);
    plan_reg(REG_DATA_BITS, 16'd8);
    plan_reg(REG_STOP_BITS, 16'd2);
    apply_regs();
    queue_ticks(40);
    settle();

    repeat (8) @(posedge clk);
    $display("%0d tick beats checked over %0d register settings", n_checked, n_settings);
    $display("%0d characters received, %0d frames started on the transmit side",
             n_rcvd, n_sent);
    if (n_fail == 0) begin
      $display("uart_serial_transceiver regression: pass");
    end else begin
      $display("uart_serial_transceiver regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
